// ===== rtl/core/pcfd_pkg.sv =====
// Package for the per-client flood detector.
// Entry layout, configuration register indexes, status codes and sequencer states.
// No dependencies.
package pcfd_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CntW  = 32;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned StatW = 3;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLE    = 3'd0,
    CFG_THRESHOLD = 3'd1,
    CFG_HARD_THR  = 3'd2,
    CFG_PERIOD    = 3'd3,
    CFG_BAN       = 3'd4
  } cfg_idx_e;

  // result status codes
  typedef enum logic [StatW-1:0] {
    ST_NORMAL     = 3'd0,
    ST_SUSPECT    = 3'd1,
    ST_FIRST_SUS  = 3'd2,
    ST_HARD       = 3'd3,
    ST_FIRST_HARD = 3'd4
  } status_e;

  // request sequencer
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_CALC,
    S_DIV,
    S_MUL,
    S_UPD
  } state_e;

  // one client entry, held by one cell of the recency chain
  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [CntW-1:0]  cnt;
    logic [TimeW-1:0] win_start;
    logic [TimeW-1:0] sus_time;
    logic [TimeW-1:0] hard_time;
  } entry_t;

  // per-cell write control
  typedef struct packed {
    logic write;
    logic shift;
  } cell_ctl_t;

endpackage

// ===== rtl/core/pcfd_if.sv =====
// Handshake channels of the per-client flood detector: request, result, config.
// Depends on pcfd_pkg.
interface pcfd_req_if;
  logic                          valid;
  logic                          ready;
  logic [pcfd_pkg::AddrW-1:0]    client_address;
  logic [pcfd_pkg::TimeW-1:0]    now_seconds;
  modport source (output valid, client_address, now_seconds, input ready);
  modport sink   (input valid, client_address, now_seconds, output ready);
endinterface

interface pcfd_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [pcfd_pkg::StatW-1:0]    status;
  logic [pcfd_pkg::CntW-1:0]     count;
  modport source (output valid, status, count, input ready);
  modport sink   (input valid, status, count, output ready);
endinterface

interface pcfd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pcfd_pkg::CfgIdxW-1:0]  index;
  logic [pcfd_pkg::CfgW-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/per_client_flood_detector.sv =====
// Per-client flood detector: recency-ordered chain of client cells plus a sequencer.
// Sequence: the request beat is taken in S_IDLE, then S_LOOK, S_CALC, S_DIV (serial divide,
// only when more than one period has elapsed), S_MUL and S_UPD, which registers the result;
// with detection disabled S_IDLE goes straight to S_UPD. One request at a time: the next
// beat is taken back in S_IDLE once the result is registered; a stalled result holds S_UPD.
// Reset (async, active low) clears all cells to empty and loads register defaults.
module per_client_flood_detector #(
  parameter int unsigned TABLE_ENTRIES = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pcfd_req_if.sink   req,
  pcfd_rsp_if.source rsp,
  pcfd_cfg_if.sink   cfg
);

  localparam int unsigned N = TABLE_ENTRIES;

  // configuration registers
  logic                      enable_q;
  logic [pcfd_pkg::CfgW-1:0] thr_q, hthr_q, per_q, ban_q;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      thr_q    <= 16'd10000;
      hthr_q   <= 16'd0;
      per_q    <= 16'd10;
      ban_q    <= 16'd300;
    end else if (cfg.valid) begin
      case (cfg.index)
        pcfd_pkg::CFG_ENABLE:    enable_q <= cfg.data[0];
        pcfd_pkg::CFG_THRESHOLD: thr_q    <= cfg.data;
        pcfd_pkg::CFG_HARD_THR:  hthr_q   <= cfg.data;
        pcfd_pkg::CFG_PERIOD:    per_q    <= cfg.data;
        pcfd_pkg::CFG_BAN:       ban_q    <= cfg.data;
        default: ;
      endcase
    end
  end

  // sequencer and request registers
  pcfd_pkg::state_e state_q, state_d;
  logic [pcfd_pkg::AddrW-1:0] addr_q;
  logic [pcfd_pkg::TimeW-1:0] now_q;
  logic                       dis_q;

  // chain
  pcfd_pkg::entry_t    ent   [N];
  pcfd_pkg::entry_t    prev  [N];
  pcfd_pkg::cell_ctl_t ctl   [N];
  logic [N-1:0]        hit, pre, sel, shift_q;
  pcfd_pkg::entry_t    new_ent;
  logic                write_en;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic raw_hit;
    pcfd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .key_i   (addr_q),
      .ctl_i   (ctl[i]),
      .prev_i  (prev[i]),
      .entry_o (ent[i]),
      .hit_o   (raw_hit)
    );
    // last cell is the fallback victim
    assign hit[i]  = (i == N - 1) ? 1'b1 : raw_hit;
    assign prev[i] = (i == 0) ? new_ent : ent[(i == 0) ? 0 : i - 1];
    assign ctl[i]  = '{write: write_en, shift: shift_q[i]};
    // any hit ahead of this cell
    if (i == 0) begin : g_p0
      assign pre[i] = 1'b0;
    end else begin : g_pn
      assign pre[i] = |hit[i-1:0];
    end
    assign sel[i] = hit[i] & ~pre[i];
  end

  // selected entry, one-hot read of the lookup
  pcfd_pkg::entry_t pick;
  always_comb begin
    pick = '0;
    for (int i = 0; i < N; i++) begin
      pick = pick | ({$bits(pcfd_pkg::entry_t){sel[i]}} & ent[i]);
    end
  end

  // working registers
  pcfd_pkg::entry_t           e_q;
  logic                       need_q, miss_q;
  logic [pcfd_pkg::TimeW-1:0] ws_q;
  logic [47:0]                prod_q;

  // window decay check
  logic [pcfd_pkg::CfgW-1:0]  per_eff;
  logic [pcfd_pkg::TimeW-1:0] elapsed;
  logic                       need;
  logic                       div_start, div_done;
  logic [pcfd_pkg::TimeW-1:0] quo;
  logic [pcfd_pkg::CfgW-1:0]  rem;

  assign per_eff = (per_q == '0) ? 16'd1 : per_q;
  assign elapsed = now_q - e_q.win_start;
  assign need    = (now_q > e_q.win_start) && (elapsed > {16'd0, per_eff});
  assign div_start = (state_q == pcfd_pkg::S_CALC) && need;

  pcfd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (elapsed),
    .divisor_i  (per_eff),
    .done_o     (div_done),
    .quo_o      (quo),
    .rem_o      (rem)
  );

  // result registers
  logic                       rsp_valid_q;
  logic [pcfd_pkg::StatW-1:0] status_q, status_c;
  logic [pcfd_pkg::CntW-1:0]  count_q;
  logic                       out_free;

  assign out_free = !rsp_valid_q || rsp.ready;
  assign req.ready = (state_q == pcfd_pkg::S_IDLE);

  // next state
  always_comb begin
    state_d  = state_q;
    write_en = 1'b0;
    case (state_q)
      pcfd_pkg::S_IDLE: if (req.valid) state_d = enable_q ? pcfd_pkg::S_LOOK
                                                           : pcfd_pkg::S_UPD;
      pcfd_pkg::S_LOOK: state_d = pcfd_pkg::S_CALC;
      pcfd_pkg::S_CALC: state_d = need ? pcfd_pkg::S_DIV : pcfd_pkg::S_MUL;
      pcfd_pkg::S_DIV:  if (div_done) state_d = pcfd_pkg::S_MUL;
      pcfd_pkg::S_MUL:  state_d = pcfd_pkg::S_UPD;
      pcfd_pkg::S_UPD: begin
        if (out_free) begin
          state_d  = pcfd_pkg::S_IDLE;
          write_en = !dis_q;
        end
      end
      default: state_d = pcfd_pkg::S_IDLE;
    endcase
  end

  // entry update: decay, floor, increment, status
  logic [pcfd_pkg::CntW-1:0] cnt_b;
  logic [pcfd_pkg::CntW-1:0] cnt_f;
  logic [32:0]               ban_end;
  always_comb begin
    new_ent = e_q;
    new_ent.win_start = ws_q;
    if (miss_q) begin
      new_ent.addr      = addr_q;
      new_ent.cnt       = '0;
      new_ent.sus_time  = '0;
      new_ent.hard_time = '0;
    end
    cnt_b = (prod_q >= {16'd0, new_ent.cnt}) ? '0 : new_ent.cnt - prod_q[31:0];
    cnt_f = (cnt_b != '1) ? cnt_b + 1'b1 : cnt_b;
    new_ent.cnt = cnt_f;
    ban_end  = {1'b0, new_ent.sus_time} + {17'd0, ban_q};
    status_c = pcfd_pkg::ST_NORMAL;
    if ((new_ent.sus_time != '0) && (ban_end > {1'b0, now_q})) begin
      status_c = pcfd_pkg::ST_SUSPECT;
      if (cnt_f > {16'd0, hthr_q}) begin
        status_c = (new_ent.hard_time == '0) ? pcfd_pkg::ST_FIRST_HARD : pcfd_pkg::ST_HARD;
        new_ent.hard_time = now_q;
      end
    end else begin
      if (new_ent.sus_time != '0) begin
        new_ent.sus_time  = '0;
        new_ent.hard_time = '0;
        new_ent.cnt       = '0;
      end
      if (new_ent.cnt > {16'd0, thr_q}) begin
        status_c = pcfd_pkg::ST_FIRST_SUS;
        new_ent.sus_time = now_q;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pcfd_pkg::S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == pcfd_pkg::S_UPD && out_free) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      pcfd_pkg::S_IDLE: begin
        addr_q <= req.client_address;
        now_q  <= req.now_seconds;
        dis_q  <= !enable_q;
      end
      // latch the selected entry and which cells shift
      pcfd_pkg::S_LOOK: begin
        e_q     <= pick;
        shift_q <= ~pre;
      end
      pcfd_pkg::S_CALC: begin
        need_q <= need;
        miss_q <= (e_q.addr != addr_q);
      end
      pcfd_pkg::S_MUL: begin
        prod_q <= (need_q && !miss_q) ? 48'(quo) * 48'(thr_q) : 48'd0;
        ws_q   <= need_q ? now_q - {16'd0, rem} : e_q.win_start;
      end
      pcfd_pkg::S_UPD: begin
        if (out_free) begin
          status_q <= dis_q ? pcfd_pkg::ST_NORMAL : status_c;
          count_q  <= dis_q ? '0 : new_ent.cnt;
        end
      end
      default: ;
    endcase
  end

  assign rsp.valid  = rsp_valid_q;
  assign rsp.status = status_q;
  assign rsp.count  = count_q;

endmodule

// ===== rtl/core/pcfd_cell.sv =====
// One cell of the recency chain: holds one client entry and flags a lookup hit.
// Depends on pcfd_pkg.
module pcfd_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [pcfd_pkg::AddrW-1:0] key_i,
  input  pcfd_pkg::cell_ctl_t        ctl_i,
  input  pcfd_pkg::entry_t           prev_i,
  output pcfd_pkg::entry_t           entry_o,
  output logic                       hit_o
);

  pcfd_pkg::entry_t entry_q;

  // take the upstream entry when the chain shifts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (ctl_i.write && ctl_i.shift) begin
      entry_q <= prev_i;
    end
  end

  // empty slot or matching address
  assign hit_o   = (entry_q.addr == '0) || (entry_q.addr == key_i);
  assign entry_o = entry_q;

endmodule

// ===== rtl/core/pcfd_div.sv =====
// Restoring divider, one quotient bit per cycle: 32-bit dividend by 16-bit divisor.
// Depends on pcfd_pkg.
module pcfd_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pcfd_pkg::TimeW-1:0] dividend_i,
  input  logic [pcfd_pkg::CfgW-1:0]  divisor_i,
  output logic                       done_o,
  output logic [pcfd_pkg::TimeW-1:0] quo_o,
  output logic [pcfd_pkg::CfgW-1:0]  rem_o
);

  localparam int unsigned StepW = $clog2(pcfd_pkg::TimeW);

  logic                       busy_q, done_q;
  logic [StepW-1:0]           step_q;
  logic [pcfd_pkg::TimeW-1:0] quo_q;
  logic [pcfd_pkg::CfgW-1:0]  rem_q, div_q;
  logic [pcfd_pkg::CfgW:0]    trial;
  logic [pcfd_pkg::CfgW:0]    diff;
  logic                       fits;

  // shift in next dividend bit, try a subtract
  always_comb begin
    trial = {rem_q, quo_q[pcfd_pkg::TimeW-1]};
    diff  = trial - {1'b0, div_q};
    fits  = trial >= {1'b0, div_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == StepW'(pcfd_pkg::TimeW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[pcfd_pkg::TimeW-2:0], fits};
      rem_q <= fits ? diff[pcfd_pkg::CfgW-1:0] : trial[pcfd_pkg::CfgW-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/core/pcfd_checker.sv =====
// Port-level checks on the per-client flood detector, bound to the top level.
// Depends on per_client_flood_detector.
module pcfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [2:0]  rsp_status,
  input logic [31:0] rsp_count
);

  // status codes stay in range
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> (rsp_status <= pcfd_pkg::ST_FIRST_HARD))
    else $error("status out of range");

  // any non-normal status means the count is at least one
  a_flag_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid && rsp_status != pcfd_pkg::ST_NORMAL) |-> (rsp_count != 32'd0))
    else $error("flagged result with zero count");

  // a result never shows up the cycle after a request beat
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid && req_ready) |=> !$rose(rsp_valid))
    else $error("result too early");

  // stalled result beat holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) && $stable(rsp_count)))
    else $error("result changed while stalled");

endmodule

bind per_client_flood_detector pcfd_checker u_pcfd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_count  (rsp.count)
);
